FILE: rtl/pnd_pkg.sv
`default_nettype none
package pnd_pkg;

   localparam int MAX_PAIRS_DEF   = 4096;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int SUM_W  = 44;
   localparam int ACC_W  = 64;
   localparam int ABS_W  = 48;
   localparam int REL_W  = 32;
   localparam int MODE_W = 2;
   localparam int CSR_W  = 2;

   localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_L2  = 2'd2;

   localparam logic CSR_NORM_MODE = 1'b0;
   localparam logic CSR_SHIFT_AVG = 1'b1;

   typedef struct packed {
      logic signed [31:0] ref_value;
      logic signed [31:0] cmp_value;
      logic               last_pair;
   } req_type;

   typedef struct packed {
      logic [ABS_W-1:0] absolute_distance;
      logic [REL_W-1:0] relative_distance;
      logic             reference_zero;
      logic             overflowed;
   } rsp_type;

   // one finished dataset handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0]  ref_sum;
      logic [SUM_W-1:0]  cmp_sum;
      logic              sat;
      logic [MODE_W-1:0] norm_mode;
      logic              shift;
   } job_type;

   // saturating signed add; top bit flags saturation
   function automatic logic [SUM_W:0] sum_add(input logic [SUM_W-1:0] acc,
                                              input logic [31:0] x);
      logic [SUM_W:0] s;
      s = {acc[SUM_W-1], acc} + {{(SUM_W+1-32){x[31]}}, x};
      if (s[SUM_W] != s[SUM_W-1]) begin
         if (s[SUM_W]) return {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
         else return {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
      end
      return {1'b0, s[SUM_W-1:0]};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pnd_udiv.sv
`default_nettype none
module pnd_udiv #(
   parameter int DW = 46,
   parameter int VW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [VW:0]   t;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      t       = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (t >= {1'b0, dvs_ff}) begin
            rem_in = VW'(t - {1'b0, dvs_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = t[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/pnd_sqrt.sv
`default_nettype none
module pnd_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] x,
   output logic             done,
   output logic [31:0]      root
);
   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = res_ff + bit_ff;
      if (start) begin
         x_in    = x;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule
`default_nettype wire

FILE: rtl/pnd_front.sv
`default_nettype none
module pnd_front #(
   parameter int MAX_PAIRS   = pnd_pkg::MAX_PAIRS_DEF,
   parameter int SAMPLE_BITS = pnd_pkg::SAMPLE_BITS_DEF,
   localparam int CNT_W      = $clog2(MAX_PAIRS + 1),
   localparam int ADDR_W     = $clog2(MAX_PAIRS)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire pnd_pkg::req_type          req,
   output logic                           full,
   input  wire logic [pnd_pkg::MODE_W-1:0] norm_mode,
   input  wire logic                      shift_average,
   input  wire logic                      lock,
   input  wire logic                      job_take,
   output logic                           job_v,
   output pnd_pkg::job_type               job,
   output logic [CNT_W-1:0]               job_count,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic [63:0]                    rd_data
);
   import pnd_pkg::*;

   logic [63:0]      mem [MAX_PAIRS];
   logic [63:0]      rd_data_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in, jcnt_ff, jcnt_in;
   logic [SUM_W-1:0] rsum_ff, rsum_in, csum_ff, csum_in;
   logic             sat_ff, sat_in, jv_ff, jv_in;
   job_type          job_ff, job_in;
   logic             accept, room;
   logic [31:0]      r32, c32;
   logic [SUM_W:0]   ra, ca;

   assign accept = push && !full;
   assign room   = cnt_ff < CNT_W'(MAX_PAIRS);
   assign r32    = 32'($signed(req.ref_value[SAMPLE_BITS-1:0]));
   assign c32    = 32'($signed(req.cmp_value[SAMPLE_BITS-1:0]));
   assign ra     = sum_add(rsum_ff, r32);
   assign ca     = sum_add(csum_ff, c32);

   always_comb begin
      cnt_in  = cnt_ff;
      rsum_in = rsum_ff;
      csum_in = csum_ff;
      sat_in  = sat_ff;
      jv_in   = jv_ff;
      job_in  = job_ff;
      jcnt_in = jcnt_ff;
      if (job_take) jv_in = 1'b0;
      if (accept) begin
         if (room) begin
            cnt_in  = cnt_ff + 1'b1;
            rsum_in = ra[SUM_W-1:0];
            csum_in = ca[SUM_W-1:0];
            sat_in  = sat_ff || ra[SUM_W] || ca[SUM_W];
         end else begin
            sat_in = 1'b1;
         end
         if (req.last_pair) begin
            jv_in            = 1'b1;
            jcnt_in          = cnt_in;
            job_in.ref_sum   = rsum_in;
            job_in.cmp_sum   = csum_in;
            job_in.sat       = sat_in;
            job_in.norm_mode = norm_mode;
            job_in.shift     = shift_average;
            cnt_in  = '0;
            rsum_in = '0;
            csum_in = '0;
            sat_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rsum_ff <= '0;
         csum_ff <= '0;
         sat_ff  <= 1'b0;
         jv_ff   <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         rsum_ff <= rsum_in;
         csum_ff <= csum_in;
         sat_ff  <= sat_in;
         jv_ff   <= jv_in;
      end
      job_ff  <= job_in;
      jcnt_ff <= jcnt_in;
   end

   always_ff @(posedge clock) begin
      if (accept && room) mem[cnt_ff[ADDR_W-1:0]] <= {r32, c32};
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign full      = jv_ff || lock;
   assign job_v     = jv_ff;
   assign job       = job_ff;
   assign job_count = jcnt_ff;
   assign rd_data   = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/pnd_back.sv
`default_nettype none
module pnd_back #(
   parameter int MAX_PAIRS = pnd_pkg::MAX_PAIRS_DEF,
   localparam int CNT_W    = $clog2(MAX_PAIRS + 1),
   localparam int ADDR_W   = $clog2(MAX_PAIRS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_v,
   input  wire pnd_pkg::job_type  job,
   input  wire logic [CNT_W-1:0]  job_count,
   output logic                   job_take,
   output logic                   lock,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  wire logic [63:0]       rd_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output pnd_pkg::rsp_type       rsp_data
);
   import pnd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_PASS = 3'd2;
   localparam logic [2:0] S_SQ1  = 3'd3;
   localparam logic [2:0] S_SQ2  = 3'd4;
   localparam logic [2:0] S_RGO  = 3'd5;
   localparam logic [2:0] S_RWT  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   localparam logic [ACC_W-1:0] ABS_MAX = {{(ACC_W-ABS_W){1'b0}}, {ABS_W{1'b1}}};

   logic [2:0]         state_ff, state_in;
   job_type            job_ff, job_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, issue_ff, issue_in;
   logic signed [47:0] offset_ff, offset_in;
   logic               neg_ff, neg_in;
   logic               s1_ff, s2_ff, s3_ff;
   logic [47:0]        dm_ff, dm_in;
   logic [31:0]        rm_ff, rm_in;
   logic [ACC_W-1:0]   dval_ff, dval_in, rval_ff, rval_in;
   logic               dsat_ff, dsat_in;
   logic [ACC_W-1:0]   dacc_ff, dacc_in, racc_ff, racc_in;
   logic               sat_ff, sat_in;
   logic [ACC_W-1:0]   absd_ff, absd_in, len_ff, len_in;
   logic [REL_W-1:0]   rel_ff, rel_in;
   logic               outv_ff, outv_in;
   rsp_type            out_ff, out_in;

   logic               is_max, is_l2, drained;
   logic [44:0]        dd, mag;
   logic               off_start, off_done;
   logic [45:0]        off_q;
   logic               sq_start, sq_done;
   logic [63:0]        sq_x;
   logic [31:0]        sq_root;
   logic               rat_start, rat_done;
   logic [79:0]        rat_q;
   logic signed [47:0] rv, cv, dlt;
   logic signed [31:0] rv32;
   logic [ACC_W:0]     dsum, rsum;

   assign is_max  = job_ff.norm_mode == MODE_MAX;
   assign is_l2   = job_ff.norm_mode != MODE_MAX && job_ff.norm_mode != MODE_SUM;
   assign dd      = {job.ref_sum[SUM_W-1], job.ref_sum} - {job.cmp_sum[SUM_W-1], job.cmp_sum};
   assign mag     = dd[44] ? 45'(0) - dd : dd;
   assign drained = issue_ff == cnt_ff && !s1_ff && !s2_ff && !s3_ff;

   assign job_take  = state_ff == S_IDLE && job_v;
   assign off_start = job_take && job.shift;
   assign lock      = state_ff == S_DIV || state_ff == S_PASS;
   assign rd_en     = state_ff == S_PASS && issue_ff < cnt_ff;
   assign rd_addr   = issue_ff[ADDR_W-1:0];
   assign sq_start  = (state_ff == S_PASS && drained && is_l2) || (state_ff == S_SQ1 && sq_done);
   assign sq_x      = state_ff == S_SQ1 ? racc_ff : dacc_ff;
   assign rat_start = state_ff == S_RGO && len_ff != '0;

   pnd_udiv #(.DW(46), .VW(CNT_W)) u_off_div (
      .clock(clock), .reset(reset), .start(off_start),
      .dividend({1'b0, mag} + 46'(job_count >> 1)), .divisor(job_count),
      .done(off_done), .quotient(off_q)
   );

   pnd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .x(sq_x),
      .done(sq_done), .root(sq_root)
   );

   pnd_udiv #(.DW(80), .VW(ACC_W)) u_rat_div (
      .clock(clock), .reset(reset), .start(rat_start),
      .dividend({absd_ff, 16'd0}), .divisor(len_ff),
      .done(rat_done), .quotient(rat_q)
   );

   // pass pipeline: read data -> magnitudes -> squares in Euclidean mode -> accumulate or max
   always_comb begin
      rv32    = rd_data[63:32];
      rv      = 48'($signed(rd_data[63:32]));
      cv      = 48'($signed(rd_data[31:0]));
      dlt     = rv - cv - offset_ff;
      dm_in   = dlt[47] ? 48'(-dlt) : 48'(dlt);
      rm_in   = rv32[31] ? 32'(-rv32) : 32'(rv32);
      dsat_in = 1'b0;
      if (is_l2) begin
         dsat_in = |dm_ff[47:32];
         dval_in = dsat_in ? {ACC_W{1'b1}} : ACC_W'(dm_ff[31:0] * dm_ff[31:0]);
         rval_in = ACC_W'(rm_ff * rm_ff);
      end else begin
         dval_in = ACC_W'(dm_ff);
         rval_in = ACC_W'(rm_ff);
      end
      dsum = {1'b0, dacc_ff} + {1'b0, dval_ff};
      rsum = {1'b0, racc_ff} + {1'b0, rval_ff};
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cnt_in    = cnt_ff;
      issue_in  = issue_ff;
      offset_in = offset_ff;
      neg_in    = neg_ff;
      dacc_in   = dacc_ff;
      racc_in   = racc_ff;
      sat_in    = sat_ff;
      absd_in   = absd_ff;
      len_in    = len_ff;
      rel_in    = rel_ff;
      outv_in   = outv_ff;
      out_in    = out_ff;
      if (rsp_pop && outv_ff) outv_in = 1'b0;
      if (rd_en) issue_in = issue_ff + 1'b1;
      if (s3_ff) begin
         if (is_max) begin
            if (dval_ff > dacc_ff) dacc_in = dval_ff;
            if (rval_ff > racc_ff) racc_in = rval_ff;
         end else begin
            dacc_in = dsum[ACC_W] ? {ACC_W{1'b1}} : dsum[ACC_W-1:0];
            racc_in = rsum[ACC_W] ? {ACC_W{1'b1}} : rsum[ACC_W-1:0];
            sat_in  = sat_ff || dsat_ff || dsum[ACC_W] || rsum[ACC_W];
         end
      end
      case (state_ff)
         S_IDLE: begin
            if (job_v) begin
               job_in    = job;
               cnt_in    = job_count;
               issue_in  = '0;
               offset_in = '0;
               neg_in    = dd[44];
               dacc_in   = '0;
               racc_in   = '0;
               sat_in    = 1'b0;
               state_in  = job.shift ? S_DIV : S_PASS;
            end
         end
         S_DIV: begin
            if (off_done) begin
               offset_in = neg_ff ? -48'(off_q) : 48'(off_q);
               state_in  = S_PASS;
            end
         end
         S_PASS: begin
            if (drained) begin
               absd_in  = dacc_ff;
               len_in   = racc_ff;
               state_in = is_l2 ? S_SQ1 : S_RGO;
            end
         end
         S_SQ1: begin
            if (sq_done) begin
               absd_in  = ACC_W'(sq_root);
               state_in = S_SQ2;
            end
         end
         S_SQ2: begin
            if (sq_done) begin
               len_in   = ACC_W'(sq_root);
               state_in = S_RGO;
            end
         end
         S_RGO: begin
            rel_in   = '0;
            state_in = len_ff == '0 ? S_OUT : S_RWT;
         end
         S_RWT: begin
            if (rat_done) begin
               rel_in   = |rat_q[79:32] ? {REL_W{1'b1}} : rat_q[31:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!outv_ff) begin
               outv_in                  = 1'b1;
               out_in.absolute_distance = absd_ff > ABS_MAX ? ABS_MAX[ABS_W-1:0]
                                                            : absd_ff[ABS_W-1:0];
               out_in.relative_distance = rel_ff;
               out_in.reference_zero    = len_ff == '0;
               out_in.overflowed        = job_ff.sat || sat_ff || absd_ff > ABS_MAX;
               state_in                 = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         outv_ff  <= 1'b0;
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
         s3_ff    <= 1'b0;
         issue_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
         s1_ff    <= rd_en;
         s2_ff    <= s1_ff;
         s3_ff    <= s2_ff;
         issue_ff <= issue_in;
         cnt_ff   <= cnt_in;
      end
      job_ff    <= job_in;
      offset_ff <= offset_in;
      neg_ff    <= neg_in;
      dm_ff     <= dm_in;
      rm_ff     <= rm_in;
      dval_ff   <= dval_in;
      rval_ff   <= rval_in;
      dsat_ff   <= dsat_in;
      dacc_ff   <= dacc_in;
      racc_ff   <= racc_in;
      sat_ff    <= sat_in;
      absd_ff   <= absd_in;
      len_ff    <= len_in;
      rel_ff    <= rel_in;
      out_ff    <= out_in;
   end

   assign rsp_empty = !outv_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && outv_ff && !rsp_pop) |=> state_ff == S_OUT)
      else $error("result overwritten before pop");
   a_off_done: assert property (@(posedge clock) disable iff (reset)
      off_done |-> state_ff == S_DIV)
      else $error("offset divide finished outside its wait");
   a_rat_done: assert property (@(posedge clock) disable iff (reset)
      rat_done |-> state_ff == S_RWT)
      else $error("ratio divide finished outside its wait");
   a_issue: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PASS |-> issue_ff <= cnt_ff)
      else $error("pass read beyond stored pairs");
`endif
endmodule
`default_nettype wire

FILE: rtl/p_norm_distance.sv
`default_nettype none
// Pairs load at one item per cycle while no dataset waits and no offset divide
// or pass runs. After the item marked last: optional mean-offset divide, a
// pass over the stored pairs, two 32-step roots in Euclidean mode, an 80-step
// ratio divide for a nonzero reference, then the result lands in the output
// register. Reset is synchronous, active high: counts, sums and flags clear;
// the pair store is not cleared and needs no sweep.
module p_norm_distance #(
   parameter int MAX_PAIRS   = pnd_pkg::MAX_PAIRS_DEF,
   parameter int SAMPLE_BITS = pnd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire pnd_pkg::req_type          req_data,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output pnd_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [pnd_pkg::CSR_W-1:0] csr_wdata
);
   import pnd_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
   localparam int ADDR_W = $clog2(MAX_PAIRS);

   // configuration registers
   logic [MODE_W-1:0] norm_ff, norm_in;
   logic              shift_ff, shift_in;

   always_comb begin
      norm_in  = norm_ff;
      shift_in = shift_ff;
      if (csr_we) begin
         if (csr_index == CSR_NORM_MODE) norm_in = csr_wdata;
         else shift_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff  <= MODE_L2;
         shift_ff <= 1'b0;
      end else begin
         norm_ff  <= norm_in;
         shift_ff <= shift_in;
      end
   end

   // front/back hand-off: one job slot, plus the store read port
   logic              lock, job_take, job_v, rd_en;
   job_type           job;
   logic [CNT_W-1:0]  job_count;
   logic [ADDR_W-1:0] rd_addr;
   logic [63:0]       rd_data;

   // front: takes items, keeps the store and running sums
   pnd_front #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset), .push(req_push), .req(req_data), .full(req_full),
      .norm_mode(norm_ff), .shift_average(shift_ff), .lock(lock),
      .job_take(job_take), .job_v(job_v), .job(job), .job_count(job_count),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // back: offset, pass, roots, ratio, result register
   pnd_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
      .clock(clock), .reset(reset), .job_v(job_v), .job(job), .job_count(job_count),
      .job_take(job_take), .lock(lock), .rd_en(rd_en), .rd_addr(rd_addr),
      .rd_data(rd_data), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire
